// File: sv/rbd_pkg.sv
package rbd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd480;

	// Row counter and height limit
	localparam int ROW_W = 11;
	localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT = 12'd2048;

	localparam int CHAN_W = 8;
	localparam int PSUM_W = CHAN_W + 1;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pix_t;

	// Horizontal pair sums, red in the low bits
	typedef struct packed {
		logic [PSUM_W-1:0] blue;
		logic [PSUM_W-1:0] green;
		logic [PSUM_W-1:0] red;
	} pix_sum_t;

	// Word handed from the scan logic to the merge stage
	typedef struct packed {
		logic     emit;
		logic     last;
		pix_sum_t sum;
	} s1_item_t;

endpackage

// File: sv/rbd_ram.sv
module rbd_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/rbd_scan.sv
module rbd_scan #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          accept,
	input  logic [rbd_pkg::CHAN_W-1:0]    red_in,
	input  logic [rbd_pkg::CHAN_W-1:0]    green_in,
	input  logic [rbd_pkg::CHAN_W-1:0]    blue_in,
	output logic                          line_we,
	output logic [$clog2(MAX_WIDTH/2)-1:0] line_addr,
	output rbd_pkg::pix_sum_t             line_wdata,
	output logic                          line_rd_en,
	output rbd_pkg::s1_item_t             item
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int AW     = $clog2(MAX_WIDTH / 2);
	localparam int WLOG_W = $clog2(MAX_WIDTH) + 1;
	localparam int CMP_W  = (rbd_pkg::CFG_DATA_W > WLOG_W) ? rbd_pkg::CFG_DATA_W : WLOG_W;

	logic [rbd_pkg::CFG_DATA_W-1:0] width_q;
	logic [rbd_pkg::CFG_DATA_W-1:0] height_q;
	logic [COL_W-1:0]               col_q;
	logic [rbd_pkg::ROW_W-1:0]      row_q;
	rbd_pkg::pix_t                  held_q;

	rbd_pkg::pix_t                  px;
	logic [CMP_W-1:0]               w_raw;
	logic [CMP_W-1:0]               w_max;
	logic [CMP_W-1:0]               w_eff;
	logic [rbd_pkg::CFG_DATA_W-1:0] h_eff;
	logic [CMP_W-1:0]               col_nxt;
	logic [rbd_pkg::CFG_DATA_W-1:0] row_nxt;
	logic                           col_wrap;
	logic                           row_wrap;
	logic                           odd_col;
	logic                           odd_row;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbd_pkg::WIDTH_RESET;
			height_q <= rbd_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				rbd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp frame size to the supported range
	always_comb begin
		w_raw = CMP_W'(width_q);
		w_max = CMP_W'(MAX_WIDTH);
		if (w_raw == '0) begin
			w_eff = CMP_W'(1);
		end else if (w_raw > w_max) begin
			w_eff = w_max;
		end else begin
			w_eff = w_raw;
		end
		if (height_q == '0) begin
			h_eff = rbd_pkg::CFG_DATA_W'(1);
		end else if (height_q > rbd_pkg::MAX_HEIGHT) begin
			h_eff = rbd_pkg::MAX_HEIGHT;
		end else begin
			h_eff = height_q;
		end
	end

	// Position of the current word
	assign px       = '{blue: blue_in, green: green_in, red: red_in};
	assign col_nxt  = CMP_W'(col_q) + CMP_W'(1);
	assign row_nxt  = rbd_pkg::CFG_DATA_W'(row_q) + rbd_pkg::CFG_DATA_W'(1);
	assign col_wrap = (col_nxt >= w_eff);
	assign row_wrap = (row_nxt >= h_eff);
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];

	// Advance column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!odd_col) begin
				held_q <= px;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_nxt[rbd_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_nxt[COL_W-1:0];
			end
		end
	end

	// Pair sum of the held left pixel and the current one
	always_comb begin
		item.sum.red   = rbd_pkg::PSUM_W'(held_q.red)   + rbd_pkg::PSUM_W'(px.red);
		item.sum.green = rbd_pkg::PSUM_W'(held_q.green) + rbd_pkg::PSUM_W'(px.green);
		item.sum.blue  = rbd_pkg::PSUM_W'(held_q.blue)  + rbd_pkg::PSUM_W'(px.blue);
		item.emit      = odd_col & odd_row;
		item.last      = (row_nxt == (h_eff & ~rbd_pkg::CFG_DATA_W'(1)))
		                 && (col_nxt == (w_eff & ~CMP_W'(1)));
	end

	// Store pair sums on even rows, fetch them on odd rows
	assign line_addr  = col_q[AW:1];
	assign line_wdata = item.sum;
	assign line_we    = accept & odd_col & ~odd_row;
	assign line_rd_en = accept & odd_col & odd_row;

endmodule

// File: sv/rbd_merge.sv
module rbd_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  rbd_pkg::s1_item_t          item,
	input  rbd_pkg::pix_sum_t          above,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rbd_pkg::CHAN_W-1:0] red_out,
	output logic [rbd_pkg::CHAN_W-1:0] green_out,
	output logic [rbd_pkg::CHAN_W-1:0] blue_out,
	output logic                       frame_last
);

	localparam int TSUM_W = rbd_pkg::PSUM_W + 1;

	logic              valid_s1;
	logic              last_s1;
	rbd_pkg::pix_sum_t sum_s1;
	logic              go;
	logic [TSUM_W-1:0] red_t;
	logic [TSUM_W-1:0] green_t;
	logic [TSUM_W-1:0] blue_t;

	// Stage 1 moves on when the output register is free or being taken
	assign go       = ~out_valid | out_ready;
	assign in_ready = ~valid_s1 | go;

	// Stage 1: pair sum waits here for the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept & item.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.emit) begin
			sum_s1  <= item.sum;
			last_s1 <= item.last;
		end
	end

	// Add the stored pair and drop the two low bits
	assign red_t   = TSUM_W'(sum_s1.red)   + TSUM_W'(above.red);
	assign green_t = TSUM_W'(sum_s1.green) + TSUM_W'(above.green);
	assign blue_t  = TSUM_W'(sum_s1.blue)  + TSUM_W'(above.blue);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && valid_s1) begin
			red_out    <= red_t[TSUM_W-1:2];
			green_out  <= green_t[TSUM_W-1:2];
			blue_out   <= blue_t[TSUM_W-1:2];
			frame_last <= last_s1;
		end
	end

endmodule

// File: sv/rgb_box_downscale_2x2_core.sv
// Channel  Dir  Handshake              Word
// in       in   in_valid / in_ready    red_in, green_in, blue_in
// out      out  out_valid / out_ready  red_out, green_out, blue_out, frame_last
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// One input word per cycle while in_ready is high; each output follows the odd-row,
// odd-column word that closes its 2x2 block through the registered line store
// read followed by the output register.
// Reset clears counters, held pixel and valid flags; the line store is not
// cleared and needs no sweep, since each odd row reads what the even row wrote.
// An output stall backs up through one stage; in_ready drops only while both
// that stage and the output register are full.
module rgb_box_downscale_2x2_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rbd_pkg::CHAN_W-1:0]     red_in,
	input  logic [rbd_pkg::CHAN_W-1:0]     green_in,
	input  logic [rbd_pkg::CHAN_W-1:0]     blue_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rbd_pkg::CHAN_W-1:0]     red_out,
	output logic [rbd_pkg::CHAN_W-1:0]     green_out,
	output logic [rbd_pkg::CHAN_W-1:0]     blue_out,
	output logic                           frame_last,
	input  logic                           cfg_we,
	input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW         = $clog2(LINE_DEPTH);

	logic              accept;
	logic              line_we;
	logic [AW-1:0]     line_addr;
	rbd_pkg::pix_sum_t line_wdata;
	logic              line_rd_en;
	rbd_pkg::pix_sum_t line_rdata;
	rbd_pkg::s1_item_t item;

	assign accept = in_valid & in_ready;

	// Counters, configuration and pair sums
	rbd_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.line_we    (line_we),
		.line_addr  (line_addr),
		.line_wdata (line_wdata),
		.line_rd_en (line_rd_en),
		.item       (item)
	);

	// Half-width line store of pair sums
	rbd_ram #(
		.WIDTH($bits(rbd_pkg::pix_sum_t)),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_addr),
		.wdata (line_wdata),
		.rd_en (line_rd_en),
		.raddr (line_addr),
		.rdata (line_rdata)
	);

	// Block sum and output register
	rbd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.above      (line_rdata),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last)
	);

endmodule

// File: sv/rbd_checker.sv
module rbd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [rbd_pkg::CHAN_W-1:0]     red_in,
	input logic [rbd_pkg::CHAN_W-1:0]     green_in,
	input logic [rbd_pkg::CHAN_W-1:0]     blue_in,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rbd_pkg::CHAN_W-1:0]     red_out,
	input logic [rbd_pkg::CHAN_W-1:0]     green_out,
	input logic [rbd_pkg::CHAN_W-1:0]     blue_out,
	input logic                           frame_last,
	input logic                           cfg_we,
	input logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_last))
		else $error("output word changed while stalled");

	// Back-pressure only from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// A fresh output follows an earlier accepted input
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output appeared without a matching input");

endmodule

bind rgb_box_downscale_2x2_core rbd_checker u_rbd_checker (.*);
